// ===== sv/htts_pkg.sv =====
package htts_pkg;

    localparam int ENTITY_MAX = 8;
    localparam int COUNT_BITS = 24;

    localparam int ENT_DEPTH = (ENTITY_MAX < 3) ? 3 : ENTITY_MAX;
    localparam int ENT_IDX_W = $clog2(ENT_DEPTH);
    localparam int ENT_LEN_W = $clog2(ENTITY_MAX + 1);

    localparam logic [ENT_LEN_W-1:0] ENT_LEN_MAX = ENT_LEN_W'(ENTITY_MAX);
    localparam logic [ENT_LEN_W-1:0] ENT_LEN_TWO = ENT_LEN_W'(2);
    localparam logic [ENT_LEN_W-1:0] ENT_LEN_THREE = ENT_LEN_W'(3);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [FIFO_CNT_W-1:0] FIFO_ROOM_TWO = FIFO_CNT_W'(FIFO_DEPTH - 2);

    localparam logic [15:0] CH_NUL = 16'h0000;
    localparam logic [15:0] CH_SPACE = 16'h0020;
    localparam logic [15:0] CH_AMP = 16'h0026;
    localparam logic [15:0] CH_QUOTE = 16'h0027;
    localparam logic [15:0] CH_SEMI = 16'h003B;
    localparam logic [15:0] CH_LT = 16'h003C;
    localparam logic [15:0] CH_EQ = 16'h003D;
    localparam logic [15:0] CH_GT = 16'h003E;
    localparam logic [15:0] CH_A = 16'h0061;
    localparam logic [15:0] CH_G = 16'h0067;
    localparam logic [15:0] CH_L = 16'h006C;
    localparam logic [15:0] CH_M = 16'h006D;
    localparam logic [15:0] CH_P = 16'h0070;
    localparam logic [15:0] CH_T = 16'h0074;

    typedef logic [23:0] char_index_t;
    typedef logic [1:0] push_num_t;

    typedef enum logic [2:0] {
        MODE_TEXT       = 3'd0,
        MODE_ENTITY     = 3'd1,
        MODE_TAG_NAME   = 3'd2,
        MODE_ATTR_NAME  = 3'd3,
        MODE_ATTR_VALUE = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        KIND_TEXT       = 3'd0,
        KIND_TAG_NAME   = 3'd1,
        KIND_ATTR_NAME  = 3'd2,
        KIND_ATTR_VALUE = 3'd3,
        KIND_TAG_END    = 3'd4,
        KIND_END        = 3'd5,
        KIND_START      = 3'd6
    } kind_t;

    typedef enum logic {
        OP_CHAR  = 1'b0,
        OP_BEGIN = 1'b1
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] ch;
        logic        last;
    } in_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] value;
        char_index_t char_index;
        logic        last_of_run;
    } out_t;

    typedef struct packed {
        push_num_t num;
        out_t      first;
        out_t      second;
    } push_t;

endpackage

// ===== sv/html_text_tag_splitter_unit.sv =====
// Splits a stream of 16-bit HTML characters into text characters (with &amp; &lt; &gt;
// decoded, other or overlong entities giving NUL) and start, tag-name, attribute-name,
// attribute-value, tag-end and end results, each carrying the saturating text count.
// A request is registered at the input and processed once the four-entry result queue
// has room for two results; a new request is taken every cycle while it has that room.
// A request yields zero, one or two results and the queue drains one result per cycle
// while m_ready is high, so the sustained rate is one request per cycle unless requests
// produce more than one result each on average, when the output port sets the pace.
module html_text_tag_splitter_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  htts_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output htts_pkg::out_t  m_data
);

    logic in_valid_reg, in_valid_next;
    htts_pkg::in_t in_data_reg;
    logic room_two, advance, s_fire;
    htts_pkg::push_t push;

    assign advance = in_valid_reg && room_two;
    assign s_ready = !in_valid_reg || advance;
    assign s_fire = s_valid && s_ready;
    assign in_valid_next = s_fire || (in_valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg <= s_data;
        end
    end

    htts_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (advance),
        .item    (in_data_reg),
        .push    (push)
    );

    htts_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room_two (room_two),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== sv/htts_core.sv =====
module htts_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             go,
    input  htts_pkg::in_t    item,
    output htts_pkg::push_t  push
);

    htts_pkg::mode_t mode_reg, mode_next;
    logic [htts_pkg::ENT_LEN_W-1:0] len_reg, len_next;
    logic ovf_reg, ovf_next;
    logic [htts_pkg::COUNT_BITS-1:0] count_reg, count_next;
    logic [15:0] ent_buf [htts_pkg::ENT_DEPTH];
    logic buf_we;

    logic main_v;
    htts_pkg::kind_t main_kind;
    logic [15:0] main_val;
    logic match_amp, match_lt, match_gt;
    logic [15:0] ent_val;
    htts_pkg::out_t res_main, res_end;

    assign match_amp = !ovf_reg && (len_reg == htts_pkg::ENT_LEN_THREE)
                       && (ent_buf[0] == htts_pkg::CH_A) && (ent_buf[1] == htts_pkg::CH_M)
                       && (ent_buf[2] == htts_pkg::CH_P);
    assign match_lt = !ovf_reg && (len_reg == htts_pkg::ENT_LEN_TWO)
                      && (ent_buf[0] == htts_pkg::CH_L) && (ent_buf[1] == htts_pkg::CH_T);
    assign match_gt = !ovf_reg && (len_reg == htts_pkg::ENT_LEN_TWO)
                      && (ent_buf[0] == htts_pkg::CH_G) && (ent_buf[1] == htts_pkg::CH_T);

    always_comb begin
        priority if (match_amp) begin
            ent_val = htts_pkg::CH_AMP;
        end else if (match_lt) begin
            ent_val = htts_pkg::CH_LT;
        end else if (match_gt) begin
            ent_val = htts_pkg::CH_GT;
        end else begin
            ent_val = htts_pkg::CH_NUL;
        end
    end

    always_comb begin
        mode_next = mode_reg;
        len_next = len_reg;
        ovf_next = ovf_reg;
        count_next = count_reg;
        buf_we = 1'b0;
        main_v = 1'b0;
        main_kind = htts_pkg::KIND_TEXT;
        main_val = htts_pkg::CH_NUL;
        if (item.op == htts_pkg::OP_BEGIN) begin
            mode_next = htts_pkg::MODE_TEXT;
            len_next = '0;
            ovf_next = 1'b0;
            main_v = 1'b1;
            main_kind = htts_pkg::KIND_START;
        end else begin
            unique case (mode_reg)
                htts_pkg::MODE_ENTITY: begin
                    if (item.ch == htts_pkg::CH_SEMI) begin
                        main_v = 1'b1;
                        main_kind = htts_pkg::KIND_TEXT;
                        main_val = ent_val;
                        if (count_reg != htts_pkg::COUNT_MAX) begin
                            count_next = count_reg + htts_pkg::COUNT_BITS'(1);
                        end
                        len_next = '0;
                        ovf_next = 1'b0;
                        mode_next = htts_pkg::MODE_TEXT;
                    end else if (len_reg < htts_pkg::ENT_LEN_MAX) begin
                        buf_we = 1'b1;
                        len_next = len_reg + htts_pkg::ENT_LEN_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                htts_pkg::MODE_TAG_NAME, htts_pkg::MODE_ATTR_NAME,
                htts_pkg::MODE_ATTR_VALUE: begin
                    main_val = item.ch;
                    if (item.ch == htts_pkg::CH_GT) begin
                        main_v = 1'b1;
                        main_kind = htts_pkg::KIND_TAG_END;
                        main_val = htts_pkg::CH_NUL;
                        mode_next = htts_pkg::MODE_TEXT;
                    end else if (mode_reg == htts_pkg::MODE_TAG_NAME) begin
                        if (item.ch == htts_pkg::CH_SPACE) begin
                            mode_next = htts_pkg::MODE_ATTR_NAME;
                        end else begin
                            main_v = 1'b1;
                            main_kind = htts_pkg::KIND_TAG_NAME;
                        end
                    end else if (mode_reg == htts_pkg::MODE_ATTR_NAME) begin
                        if (item.ch == htts_pkg::CH_EQ) begin
                            mode_next = htts_pkg::MODE_ATTR_VALUE;
                        end else if (item.ch != htts_pkg::CH_SPACE) begin
                            main_v = 1'b1;
                            main_kind = htts_pkg::KIND_ATTR_NAME;
                        end
                    end else if (item.ch != htts_pkg::CH_SPACE
                                 && item.ch != htts_pkg::CH_QUOTE) begin
                        main_v = 1'b1;
                        main_kind = htts_pkg::KIND_ATTR_VALUE;
                    end
                end
                default: begin
                    if (item.ch == htts_pkg::CH_AMP) begin
                        len_next = '0;
                        ovf_next = 1'b0;
                        mode_next = htts_pkg::MODE_ENTITY;
                    end else if (item.ch == htts_pkg::CH_LT) begin
                        mode_next = htts_pkg::MODE_TAG_NAME;
                    end else begin
                        main_v = 1'b1;
                        main_kind = htts_pkg::KIND_TEXT;
                        main_val = item.ch;
                        if (count_reg != htts_pkg::COUNT_MAX) begin
                            count_next = count_reg + htts_pkg::COUNT_BITS'(1);
                        end
                    end
                end
            endcase
        end
        if (item.last) begin
            mode_next = htts_pkg::MODE_TEXT;
            len_next = '0;
            ovf_next = 1'b0;
        end
    end

    always_comb begin
        res_main.kind = main_kind;
        res_main.value = main_val;
        res_main.char_index = htts_pkg::char_index_t'(count_next);
        res_main.last_of_run = !item.last;
        res_end.kind = htts_pkg::KIND_END;
        res_end.value = htts_pkg::CH_NUL;
        res_end.char_index = htts_pkg::char_index_t'(count_next);
        res_end.last_of_run = 1'b1;
        push.second = res_end;
        if (main_v) begin
            push.first = res_main;
            push.num = item.last ? 2'd2 : 2'd1;
        end else begin
            push.first = res_end;
            push.num = item.last ? 2'd1 : 2'd0;
        end
        if (!go) begin
            push.num = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= htts_pkg::MODE_TEXT;
            len_reg <= '0;
            ovf_reg <= 1'b0;
            count_reg <= '0;
        end else if (go) begin
            mode_reg <= mode_next;
            len_reg <= len_next;
            ovf_reg <= ovf_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (go && buf_we) begin
            ent_buf[len_reg[htts_pkg::ENT_IDX_W-1:0]] <= item.ch;
        end
    end

endmodule

// ===== sv/htts_fifo.sv =====
module htts_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  htts_pkg::push_t  push,
    output logic             room_two,
    output logic             m_valid,
    input  logic             m_ready,
    output htts_pkg::out_t   m_data
);

    htts_pkg::out_t mem [htts_pkg::FIFO_DEPTH];
    logic [htts_pkg::FIFO_PTR_W-1:0] wr_reg, rd_reg;
    logic [htts_pkg::FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic pop;

    assign m_valid = (cnt_reg != '0);
    assign m_data = mem[rd_reg];
    assign pop = m_valid && m_ready;
    assign room_two = (cnt_reg <= htts_pkg::FIFO_ROOM_TWO);
    assign cnt_next = cnt_reg + htts_pkg::FIFO_CNT_W'(push.num)
                      - htts_pkg::FIFO_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg <= wr_reg + htts_pkg::FIFO_PTR_W'(push.num);
            rd_reg <= rd_reg + htts_pkg::FIFO_PTR_W'(pop);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            mem[wr_reg] <= push.first;
        end
        if (push.num == 2'd2) begin
            mem[wr_reg + htts_pkg::FIFO_PTR_W'(1)] <= push.second;
        end
    end

endmodule
